@@ sv/mosl_pkg.sv @@
// shared constants and types for the median-of-two-sorted-lists unit
package mosl_pkg;

  // list capacity and derived widths
  localparam int unsigned MaxLen  = 1024;
  localparam int unsigned AddrW   = $clog2(MaxLen);
  localparam int unsigned CntW    = AddrW + 1;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;

  // stream payload widths
  localparam int unsigned InDataW  = 2 * DataW;
  localparam int unsigned OutBits  = 2 * DataW + StatusW;
  localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

  // status codes
  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusEmpty   = 2'd1;
  localparam logic [StatusW-1:0] StatusDropped = 2'd2;

  // store access from the sequencer
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [AddrW-1:0] raddr_x;
    logic [AddrW-1:0] raddr_y;
  } mosl_mem_req_t;

  // shared compare unit outputs
  typedef struct packed {
    logic             lt;
    logic [DataW-1:0] min;
    logic [DataW-1:0] max;
  } mosl_cmp_t;

  // finished result
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   upper;
    logic [DataW-1:0]   lower;
  } mosl_res_t;

endpackage

@@ sv/mosl_ram.sv @@
// generic single write, single read ram with registered read data
module mosl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/mosl_minmax.sv @@
// shared signed compare unit: less-than plus min and max select
module mosl_minmax (
  input  logic [mosl_pkg::DataW-1:0] a_i,
  input  logic [mosl_pkg::DataW-1:0] b_i,
  output mosl_pkg::mosl_cmp_t        cmp_o
);

  // a below b in signed order picks a as the minimum
  always_comb begin
    cmp_o.lt  = $signed(a_i) < $signed(b_i);
    cmp_o.min = cmp_o.lt ? a_i : b_i;
    cmp_o.max = cmp_o.lt ? b_i : a_i;
  end

endmodule

@@ sv/mosl_seq.sv @@
// load counter and halving-search sequencer around the shared compare unit
module mosl_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         in_last_i,
  output mosl_pkg::mosl_mem_req_t      mem_o,
  input  logic [mosl_pkg::DataW-1:0]   x_rdata_i,
  input  logic [mosl_pkg::DataW-1:0]   y_rdata_i,
  output logic [mosl_pkg::DataW-1:0]   cmp_a_o,
  output logic [mosl_pkg::DataW-1:0]   cmp_b_o,
  input  mosl_pkg::mosl_cmp_t          cmp_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output mosl_pkg::mosl_res_t          res_o
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MID  = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_F0   = 3'd3;
  localparam logic [2:0] S_F1   = 3'd4;
  localparam logic [2:0] S_F2   = 3'd5;
  localparam logic [2:0] S_F3   = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  localparam logic [mosl_pkg::CntW-1:0] CntMax = mosl_pkg::CntW'(mosl_pkg::MaxLen);
  localparam logic [mosl_pkg::CntW-1:0] CntOne = mosl_pkg::CntW'(1);
  localparam logic [mosl_pkg::CntW-1:0] CntTwo = mosl_pkg::CntW'(2);

  logic [2:0]                      state_q, state_d;
  logic [mosl_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic                            ovf_q, ovf_d;
  logic [mosl_pkg::AddrW-1:0]      fb_q, fb_d, sb_q, sb_d;
  logic [mosl_pkg::CntW-1:0]       ws_q, ws_d;
  logic [mosl_pkg::DataW-1:0]      lo_q, lo_d, hi_q, hi_d, a_q, a_d, b_q, b_d;
  logic [mosl_pkg::StatusW-1:0]    status_q, status_d;

  logic                            accept;
  logic                            room;
  logic [mosl_pkg::CntW-1:0]       n_total;
  logic [mosl_pkg::CntW-1:0]       mid;
  logic [mosl_pkg::CntW-1:0]       keep;
  logic [mosl_pkg::CntW-1:0]       cut;

  assign in_ready_o = (state_q == S_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign room       = (cnt_q < CntMax);
  assign n_total    = room ? cnt_q + CntOne : cnt_q;

  // window arithmetic for one halving round
  assign mid  = (ws_q - CntOne) >> 1;
  assign keep = (ws_q >> 1) + CntOne;
  assign cut  = ws_q - keep;

  // store write and read addresses
  always_comb begin
    mem_o.we    = accept && room;
    mem_o.waddr = cnt_q[mosl_pkg::AddrW-1:0];
    unique case (state_q)
      S_MID: begin
        mem_o.raddr_x = fb_q + mid[mosl_pkg::AddrW-1:0];
        mem_o.raddr_y = sb_q + mid[mosl_pkg::AddrW-1:0];
      end
      S_F1: begin
        mem_o.raddr_x = fb_q + mosl_pkg::AddrW'(1);
        mem_o.raddr_y = sb_q + mosl_pkg::AddrW'(1);
      end
      default: begin
        mem_o.raddr_x = fb_q;
        mem_o.raddr_y = sb_q;
      end
    endcase
  end

  // compare operands: second list first so lt means y below x, held b and a in S_F3
  always_comb begin
    if (state_q == S_F3) begin
      cmp_a_o = b_q;
      cmp_b_o = a_q;
    end else begin
      cmp_a_o = y_rdata_i;
      cmp_b_o = x_rdata_i;
    end
  end

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    fb_d     = fb_q;
    sb_d     = sb_q;
    ws_d     = ws_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    a_d      = a_q;
    b_d      = b_q;
    status_d = status_q;
    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          if (room) begin
            cnt_d = cnt_q + CntOne;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_last_i) begin
            cnt_d = '0;
            ovf_d = 1'b0;
            fb_d  = '0;
            sb_d  = '0;
            ws_d  = n_total;
            priority if (n_total == '0) begin
              status_d = mosl_pkg::StatusEmpty;
              lo_d     = '0;
              hi_d     = '0;
              state_d  = S_DONE;
            end else begin
              status_d = (ovf_q || !room) ? mosl_pkg::StatusDropped : mosl_pkg::StatusOk;
              state_d  = (n_total > CntTwo) ? S_MID : S_F0;
            end
          end
        end
      end
      S_MID: state_d = S_CMP;
      S_CMP: begin
        if (cmp_i.lt) begin
          sb_d = sb_q + cut[mosl_pkg::AddrW-1:0];
        end else begin
          fb_d = fb_q + cut[mosl_pkg::AddrW-1:0];
        end
        ws_d    = keep;
        state_d = (keep > CntTwo) ? S_MID : S_F0;
      end
      S_F0: state_d = S_F1;
      S_F1: begin
        a_d     = cmp_i.max;
        lo_d    = cmp_i.min;
        hi_d    = cmp_i.max;
        state_d = (ws_q == CntOne) ? S_DONE : S_F2;
      end
      S_F2: begin
        b_d     = cmp_i.min;
        state_d = S_F3;
      end
      S_F3: begin
        lo_d    = cmp_i.min;
        hi_d    = cmp_i.max;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      fb_q    <= '0;
      sb_q    <= '0;
      ws_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      fb_q    <= fb_d;
      sb_q    <= sb_d;
      ws_q    <= ws_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    a_q      <= a_d;
    b_q      <= b_d;
    status_q <= status_d;
  end

  assign res_valid_o  = (state_q == S_DONE);
  assign res_o.lower  = lo_q;
  assign res_o.upper  = hi_q;
  assign res_o.status = status_q;

  // a halving round only runs on a window wider than two
  a_round_wide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (ws_q > CntTwo))
    else $error("halving round on a narrow window");

  // each round keeps half plus one
  a_round_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |=> (ws_q == ($past(ws_q) >> 1) + CntOne))
    else $error("window did not shrink as expected");

  // load count stays within capacity
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CntMax) && (ws_q <= CntMax))
    else $error("count beyond capacity");

endmodule

@@ sv/median_of_two_sorted_lists_unit.sv @@
// Top level of the median-of-two-sorted-lists unit.
// Loading: one element pair per cycle, ready while the block is loading.
// Search after the last transfer: each halving round is a store read (S_MID), then a compare
// (S_CMP) while the window is wider than two; S_F0, S_F1 and, for a window of two, S_F2, S_F3 finish.
// Result sits in an output register; the next load starts once it is handed over.
// Reset (rst_ni low, asynchronous) clears the sequencer and counts; stores are not cleared.
module median_of_two_sorted_lists_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: x_value [31:0], y_value [63:32]
  input  logic [mosl_pkg::InDataW-1:0]    s_axis_tdata_i,
  input  logic                            s_axis_tlast_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: lower_median [31:0], upper_median [63:32], status [65:64], zero fill
  output logic [mosl_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  mosl_pkg::mosl_mem_req_t        mem;
  mosl_pkg::mosl_cmp_t            cmp;
  mosl_pkg::mosl_res_t            res;
  logic [mosl_pkg::DataW-1:0]     x_rdata, y_rdata;
  logic [mosl_pkg::DataW-1:0]     cmp_a, cmp_b;
  logic                           res_valid, res_ready;
  logic                           out_vld_q;
  logic [mosl_pkg::OutDataW-1:0]  out_data_q;

  // first and second list stores
  mosl_ram #(
    .Width(mosl_pkg::DataW),
    .Depth(mosl_pkg::MaxLen)
  ) u_ram_x (
    .clk_i  (clk_i),
    .we_i   (mem.we),
    .waddr_i(mem.waddr),
    .wdata_i(s_axis_tdata_i[mosl_pkg::DataW-1:0]),
    .raddr_i(mem.raddr_x),
    .rdata_o(x_rdata)
  );

  mosl_ram #(
    .Width(mosl_pkg::DataW),
    .Depth(mosl_pkg::MaxLen)
  ) u_ram_y (
    .clk_i  (clk_i),
    .we_i   (mem.we),
    .waddr_i(mem.waddr),
    .wdata_i(s_axis_tdata_i[2*mosl_pkg::DataW-1:mosl_pkg::DataW]),
    .raddr_i(mem.raddr_y),
    .rdata_o(y_rdata)
  );

  // shared compare unit
  mosl_minmax u_cmp (
    .a_i  (cmp_a),
    .b_i  (cmp_b),
    .cmp_o(cmp)
  );

  // sequencer
  mosl_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_last_i  (s_axis_tlast_i),
    .mem_o      (mem),
    .x_rdata_i  (x_rdata),
    .y_rdata_i  (y_rdata),
    .cmp_a_o    (cmp_a),
    .cmp_b_o    (cmp_b),
    .cmp_i      (cmp),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // output register, refilled when empty or being drained
  assign res_ready = !out_vld_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= mosl_pkg::OutDataW'(res);
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
